/* design/imu_frame_parser_yaw_filter_unit_macros.svh */
// Assertion macros for the checker file of the frame parser.
`ifndef IMU_FRAME_PARSER_YAW_FILTER_UNIT_MACROS_SVH
`define IMU_FRAME_PARSER_YAW_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is low.
`define IMUFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is low.
`define IMUFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define IMUFP_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/imufp_pkg.sv */
package imufp_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES = 11;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  // Frame byte positions of the fields that are latched.
  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_KIND   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_Z_LOW  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_Z_HIGH = POS_W'(7);

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_KIND   = 2'd2;
  localparam logic [1:0] ST_BAD_SUM    = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_WEIGHT   = 2'd3;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic [7:0]  RST_HEADER_VALUE = 8'd85;
  localparam logic [7:0]  RST_ANGLE_CODE   = 8'd83;
  localparam logic [7:0]  RST_RATE_CODE    = 8'd82;
  localparam logic [15:0] RST_YAW_WEIGHT   = 16'd58982;

  // Yaw arithmetic widths.
  localparam int YAW_W  = 24;
  localparam int PROD_W = 41;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 41'sd32768;

  // Check result of a completed frame, handed from the parser to the filter.
  typedef struct packed {
    logic        last;
    logic [1:0]  status;
    logic        is_angle;
    logic        is_rate;
    logic [15:0] z16;
  } imufp_res_t;

endpackage

/* design/imufp_parse.sv */
module imufp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  logic               fire_i,
  input  logic [7:0]         data_i,
  input  logic               first_i,
  input  logic [7:0]         header_value_i,
  input  logic [7:0]         angle_code_i,
  input  logic [7:0]         rate_code_i,
  output imufp_pkg::imufp_res_t res_o
);
  import imufp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       sum_r, sum_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       kind_r, kind_nxt;
  logic [7:0]       z_low_r, z_high_r;
  logic             is_last;
  logic             kind_angle, kind_rate;

  // Position of the current byte; the first-byte flag realigns the frame.
  assign pos_cur = first_i ? POS_HEADER : pos_r;
  assign is_last = (pos_cur >= LAST_POS);

  // Frame state for the next byte.
  always_comb begin
    pos_nxt    = is_last ? POS_HEADER : pos_cur + POS_W'(1);
    sum_nxt    = sum_r;
    hdr_ok_nxt = hdr_ok_r;
    kind_nxt   = kind_r;
    if (pos_cur == POS_HEADER) begin
      sum_nxt    = 8'd0;
      hdr_ok_nxt = (data_i == header_value_i);
    end
    if (pos_cur == POS_KIND) begin
      kind_nxt = data_i;
    end
    if (!is_last) begin
      sum_nxt = sum_nxt + data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      hdr_ok_r <= 1'b0;
      kind_r   <= '0;
    end else if (fire_i) begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      kind_r   <= kind_nxt;
    end
  end

  // The Z bytes are always written before any frame can complete.
  always_ff @(posedge clk) begin
    if (fire_i && (pos_cur == POS_Z_LOW)) begin
      z_low_r <= data_i;
    end
    if (fire_i && (pos_cur == POS_Z_HIGH)) begin
      z_high_r <= data_i;
    end
  end

  // Checks on the last byte: header first, then type, then checksum.
  assign kind_angle = (kind_r == angle_code_i);
  assign kind_rate  = (kind_r == rate_code_i);

  always_comb begin
    res_o.last     = valid_i && is_last;
    res_o.z16      = {z_high_r, z_low_r};
    res_o.is_angle = 1'b0;
    res_o.is_rate  = 1'b0;
    if (!hdr_ok_r) begin
      res_o.status = ST_BAD_HEADER;
    end else if (!kind_angle && !kind_rate) begin
      res_o.status = ST_BAD_KIND;
    end else if (sum_r != data_i) begin
      res_o.status = ST_BAD_SUM;
    end else begin
      res_o.status   = ST_OK;
      res_o.is_angle = kind_angle;
      res_o.is_rate  = !kind_angle;
    end
  end

endmodule

/* design/imu_frame_parser_yaw_filter_unit.sv */
// Sensor frame parser with yaw filter. One frame byte is taken per cycle
// while the input is not stalled; a byte that does not end a frame only
// passes through the input register. The last byte of a frame produces one
// result item through the input register, the header/type/checksum check
// with the yaw difference, the 24x17 weight multiply, then rounding and the
// yaw add into the output register. Only one frame result is in the
// check-to-multiply path at a time, so a last byte that arrives while the
// previous result is still blocked there by output stall waits in the input
// register. The output register decouples the sides: bytes keep flowing
// while a result waits. Yaw is signed Q16.8 in raw angle units (32768.0 is
// 180 degrees) and wraps modulo a full circle.
module imu_frame_parser_yaw_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_first_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic                                out_frame_kind,
  output logic signed [23:0]                  out_yaw_out,
  output logic signed [15:0]                  out_rate_out,
  input  logic                                cfg_we,
  input  logic [imufp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imufp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import imufp_pkg::*;

  // Configuration registers.
  logic [7:0]  header_value_r, angle_code_r, rate_code_r;
  logic [15:0] yaw_weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= RST_HEADER_VALUE;
      angle_code_r   <= RST_ANGLE_CODE;
      rate_code_r    <= RST_RATE_CODE;
      yaw_weight_r   <= RST_YAW_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_VALUE: header_value_r <= cfg_wdata[7:0];
        CFG_ANGLE_CODE:   angle_code_r   <= cfg_wdata[7:0];
        CFG_RATE_CODE:    rate_code_r    <= cfg_wdata[7:0];
        CFG_YAW_WEIGHT:   yaw_weight_r   <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Input register.
  logic       a_valid_r;
  logic [7:0] a_data_r;
  logic       a_first_r;
  logic       a_go, a_fire, in_acc;
  imufp_res_t res;

  // Check and multiply stages.
  logic                     b_valid_r, c_valid_r;
  logic [1:0]               b_status_r, c_status_r;
  logic                     b_angle_r, c_angle_r;
  logic                     b_rate_r, c_rate_r;
  logic [15:0]              b_z16_r, c_z16_r;
  logic [YAW_W-1:0]         b_delta_r;
  logic signed [PROD_W-1:0] c_prod_r;

  // Filter state and output register.
  logic [YAW_W-1:0]         yaw_r, yaw_nxt;
  logic [15:0]              rate_r, rate_nxt;
  logic signed [PROD_W-1:0] rounded;
  logic                     out_valid_r, en_out;

  // A frame result enters the check stage only when that path is empty.
  assign a_go     = !res.last || !(b_valid_r || c_valid_r);
  assign a_fire   = a_valid_r && a_go;
  assign in_stall = a_valid_r && !a_go;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_data_r  <= in_data_byte;
      a_first_r <= in_first_byte;
    end
  end

  imufp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_i        (a_valid_r),
    .fire_i         (a_fire),
    .data_i         (a_data_r),
    .first_i        (a_first_r),
    .header_value_i (header_value_r),
    .angle_code_i   (angle_code_r),
    .rate_code_i    (rate_code_r),
    .res_o          (res)
  );

  // Check stage register: status and the wrapped yaw difference.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_fire && res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && res.last) begin
      b_status_r <= res.status;
      b_angle_r  <= res.is_angle;
      b_rate_r   <= res.is_rate;
      b_z16_r    <= res.z16;
      b_delta_r  <= {res.z16, 8'd0} - yaw_r;
    end
  end

  // Multiply stage: signed difference times the unsigned weight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (b_valid_r) begin
      c_valid_r <= 1'b1;
    end else if (en_out) begin
      c_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      c_status_r <= b_status_r;
      c_angle_r  <= b_angle_r;
      c_rate_r   <= b_rate_r;
      c_z16_r    <= b_z16_r;
      c_prod_r   <= $signed(b_delta_r) * $signed({1'b0, yaw_weight_r});
    end
  end

  // Round half up, drop the 16 fraction bits and add the step to the yaw.
  assign rounded = c_prod_r + ROUND_HALF;

  always_comb begin
    yaw_nxt  = yaw_r;
    rate_nxt = rate_r;
    if (c_angle_r) begin
      yaw_nxt = yaw_r + rounded[YAW_W+15:16];
    end
    if (c_rate_r) begin
      rate_nxt = c_z16_r;
    end
  end

  assign en_out = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      yaw_r       <= '0;
      rate_r      <= '0;
    end else if (en_out) begin
      out_valid_r <= c_valid_r;
      if (c_valid_r) begin
        yaw_r  <= yaw_nxt;
        rate_r <= rate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && c_valid_r) begin
      out_status     <= c_status_r;
      out_frame_kind <= c_rate_r;
      out_yaw_out    <= $signed(yaw_nxt);
      out_rate_out   <= $signed(rate_nxt);
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/imufp_checker.sv */
`include "imu_frame_parser_yaw_filter_unit_macros.svh"

module imufp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic               out_frame_kind,
  input logic signed [23:0] out_yaw_out,
  input logic signed [15:0] out_rate_out
);
  import imufp_pkg::*;

  // Reset leaves no result item pending.
  `IMUFP_ASSERT_NEXT_ALWAYS(a_reset_clears, !rst_n, !out_valid, "result valid after reset")

  // Reset empties the input register, so the input is not stalled.
  `IMUFP_ASSERT_NEXT_ALWAYS(a_reset_no_stall, !rst_n, !in_stall, "input stalled after reset")

  // A failed frame never reports a frame kind.
  `IMUFP_ASSERT_NOW(a_fail_kind, out_valid && (out_status != ST_OK), !out_frame_kind,
                    "failed frame with rate kind")

  // A stalled result item holds all of its fields.
  `IMUFP_ASSERT_NEXT(a_hold_result, out_valid && out_stall,
                     out_valid && $stable(out_status) && $stable(out_frame_kind) &&
                     $stable(out_yaw_out) && $stable(out_rate_out),
                     "stalled result changed")

endmodule

bind imu_frame_parser_yaw_filter_unit imufp_checker u_imufp_checker (.*);

/* dv/imu_frame_parser_yaw_filter_unit_checker.sv */
`timescale 1ns / 100ps

// Watches the byte, result and register ports of the frame parser, predicts
// every frame result and compares it with what comes out.
module imu_frame_parser_yaw_filter_unit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_first_byte,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [1:0]                          out_status,
  input  logic                                out_frame_kind,
  input  logic signed [23:0]                  out_yaw_out,
  input  logic signed [15:0]                  out_rate_out,
  input  logic                                cfg_we,
  input  logic [imufp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imufp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic        kind;
    logic [23:0] yaw;
    logic [15:0] rate;
  } frame_result_t;

  // Results of completed frames that have not come out yet, oldest first.
  frame_result_t frame_results[$];

  // Register copies.
  logic [7:0]  header_code;
  logic [7:0]  angle_code;
  logic [7:0]  rate_code;
  logic [15:0] yaw_gain;

  // Parser and filter state.
  logic [3:0]  position;
  logic [7:0]  running_sum;
  logic        header_good;
  logic [7:0]  kind_seen;
  logic [7:0]  z_lo;
  logic [7:0]  z_hi;
  logic [23:0] yaw_est;
  logic [15:0] rate_hold;

  // Moves the yaw toward the new angle by the weighted wrapped difference.
  // The step is rounded half up, which is a floor after adding one half.
  function automatic logic [23:0] filtered_yaw(input logic [23:0] yaw,
                                               input logic [15:0] z16,
                                               input logic [15:0] gain);
    logic [23:0] diff;
    longint      diff_s;
    longint      gain_s;
    longint      step;
    diff   = {z16, 8'h00} - yaw;
    diff_s = $signed(diff);
    gain_s = gain;
    step   = (diff_s * gain_s + 64'sd32768) >>> 16;
    return yaw + step[23:0];
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    logic [3:0]    pos;
    if (!rst_n) begin
      header_code = imufp_pkg::RST_HEADER_VALUE;
      angle_code  = imufp_pkg::RST_ANGLE_CODE;
      rate_code   = imufp_pkg::RST_RATE_CODE;
      yaw_gain    = imufp_pkg::RST_YAW_WEIGHT;
      position    = '0;
      running_sum = '0;
      header_good = 1'b0;
      kind_seen   = '0;
      z_lo        = '0;
      z_hi        = '0;
      yaw_est     = '0;
      rate_hold   = '0;
      frame_results.delete();
      pending = 0;
    end else begin
      // Compare an accepted result item with the oldest prediction.
      if (out_valid && !out_stall) begin
        got = '{out_status, out_frame_kind, out_yaw_out, out_rate_out};
        if (frame_results.size() == 0) begin
          fail_count++;
          $error("result item with no frame pending: status %0d kind %0d yaw %0d rate %0d",
                 out_status, out_frame_kind, out_yaw_out, out_rate_out);
        end else begin
          want = frame_results.pop_front();
          if (got.status !== want.status) begin
            fail_count++;
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
          end
          if (got.kind !== want.kind) begin
            fail_count++;
            $error("frame_kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
          end
          if (got.yaw !== want.yaw) begin
            fail_count++;
            $error("yaw_out mismatch: expected %0d, actual %0d",
                   $signed(want.yaw), $signed(got.yaw));
          end
          if (got.rate !== want.rate) begin
            fail_count++;
            $error("rate_out mismatch: expected %0d, actual %0d",
                   $signed(want.rate), $signed(got.rate));
          end
        end
      end

      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          imufp_pkg::CFG_HEADER_VALUE: header_code = cfg_wdata[7:0];
          imufp_pkg::CFG_ANGLE_CODE:   angle_code  = cfg_wdata[7:0];
          imufp_pkg::CFG_RATE_CODE:    rate_code   = cfg_wdata[7:0];
          imufp_pkg::CFG_YAW_WEIGHT:   yaw_gain    = cfg_wdata[15:0];
          default: ;
        endcase
      end

      // Track an accepted frame byte; the last one yields a result.
      if (in_valid && !in_stall) begin
        pos = in_first_byte ? 4'd0 : position;
        if (pos == 4'(imufp_pkg::POS_HEADER)) begin
          running_sum = '0;
          header_good = (in_data_byte == header_code);
        end
        if (pos == 4'(imufp_pkg::POS_KIND))   kind_seen = in_data_byte;
        if (pos == 4'(imufp_pkg::POS_Z_LOW))  z_lo = in_data_byte;
        if (pos == 4'(imufp_pkg::POS_Z_HIGH)) z_hi = in_data_byte;
        if (pos < 4'(imufp_pkg::LAST_POS)) begin
          running_sum = running_sum + in_data_byte;
          position    = pos + 4'd1;
        end else begin
          position  = '0;
          want.kind = 1'b0;
          if (!header_good) begin
            want.status = imufp_pkg::ST_BAD_HEADER;
          end else if (kind_seen != angle_code && kind_seen != rate_code) begin
            want.status = imufp_pkg::ST_BAD_KIND;
          end else if (running_sum != in_data_byte) begin
            want.status = imufp_pkg::ST_BAD_SUM;
          end else begin
            want.status = imufp_pkg::ST_OK;
            if (kind_seen == angle_code) begin
              yaw_est = filtered_yaw(yaw_est, {z_hi, z_lo}, yaw_gain);
            end else begin
              rate_hold = {z_hi, z_lo};
              want.kind = 1'b1;
            end
          end
          want.yaw  = yaw_est;
          want.rate = rate_hold;
          frame_results.push_back(want);
        end
      end
      pending = frame_results.size();
    end
  end

endmodule

/* dv/tb_imu_frame_parser_yaw_filter_unit.sv */
`timescale 1ns / 100ps

module tb_imu_frame_parser_yaw_filter_unit;
  import imufp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 150;
  localparam int SETTLE_TICKS = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_first_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic                  out_frame_kind;
  logic signed [23:0]    out_yaw_out;
  logic signed [15:0]    out_rate_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_bytes = 0;
  bit quiet = 1'b0;

  // Register values that the frame builder aims at.
  logic [7:0] cur_header = RST_HEADER_VALUE;
  logic [7:0] cur_angle  = RST_ANGLE_CODE;
  logic [7:0] cur_rate   = RST_RATE_CODE;

  imu_frame_parser_yaw_filter_unit DUT (.*);

  imu_frame_parser_yaw_filter_unit_checker frame_checker (.*);

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random back-pressure on results, off during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  // Offers one byte after an optional random gap and holds it until taken.
  task automatic send_byte(input logic [7:0] data, input logic first);
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_first_byte <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  // Builds and sends one frame, optionally spoiled in the header, the type
  // or the checksum byte.
  task automatic send_frame(input logic [1:0] fault, input bit angle_frame,
                            input bit flagged, input logic [15:0] z16);
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] sum;
    frame[0] = cur_header;
    if (fault == ST_BAD_HEADER) frame[0] = cur_header ^ 8'($urandom_range(1, 255));
    frame[1] = angle_frame ? cur_angle : cur_rate;
    if (fault == ST_BAD_KIND) begin
      do frame[1] = 8'($urandom);
      while (frame[1] == cur_angle || frame[1] == cur_rate);
    end
    for (int i = 2; i < FRAME_BYTES - 1; i++) frame[i] = 8'($urandom);
    frame[POS_Z_LOW]  = z16[7:0];
    frame[POS_Z_HIGH] = z16[15:8];
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum += frame[i];
    frame[FRAME_BYTES-1] = sum;
    if (fault == ST_BAD_SUM) frame[FRAME_BYTES-1] = sum + 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame[i], flagged && i == 0);
  endtask

  // Z values lean toward the wrap points now and then.
  function automatic logic [15:0] pick_z();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly whole frames with random content, the rest stray bytes and
  // frames cut short by a new start flag.
  task automatic random_traffic(input int budget);
    int stop_at;
    int choice;
    int count;
    stop_at = sent_bytes + budget;
    while (sent_bytes < stop_at) begin
      choice = $urandom_range(99);
      if (choice < 60) begin
        send_frame(ST_OK, 1'($urandom_range(1)), $urandom_range(9) != 0, pick_z());
      end else if (choice < 68) begin
        send_frame(ST_BAD_HEADER, 1'($urandom_range(1)), 1'b1, pick_z());
      end else if (choice < 76) begin
        send_frame(ST_BAD_KIND, 1'($urandom_range(1)), 1'b1, pick_z());
      end else if (choice < 84) begin
        send_frame(ST_BAD_SUM, 1'($urandom_range(1)), 1'b1, pick_z());
      end else if (choice < 92) begin
        count = $urandom_range(1, 12);
        repeat (count) send_byte(8'($urandom), $urandom_range(15) == 0);
      end else begin
        count = $urandom_range(1, FRAME_BYTES - 1);
        send_byte(cur_header, 1'b1);
        repeat (count - 1) send_byte(8'($urandom), 1'b0);
      end
    end
    // Close on a clean frame so the parser sits at byte zero.
    send_frame(ST_OK, 1'b1, 1'b1, pick_z());
  endtask

  // Stops offering bytes and lets every pending result come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // Writes all four registers; the upper data bits of byte registers are junk.
  task automatic program_regs(input logic [7:0] hdr, angle, rate, input logic [15:0] gain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER_VALUE;
    cfg_wdata <= {8'($urandom), hdr};
    @(negedge clk);
    cfg_index <= CFG_ANGLE_CODE;
    cfg_wdata <= {8'($urandom), angle};
    @(negedge clk);
    cfg_index <= CFG_RATE_CODE;
    cfg_wdata <= {8'($urandom), rate};
    @(negedge clk);
    cfg_index <= CFG_YAW_WEIGHT;
    cfg_wdata <= gain;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cur_header = hdr;
    cur_angle  = angle;
    cur_rate   = rate;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a frame cut short by a new start, a flagged angle frame at
    // -180 degrees, then a rate frame found by counting alone.
    send_byte(cur_header, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_frame(ST_OK, 1'b1, 1'b1, 16'h8000);
    send_frame(ST_OK, 1'b0, 1'b0, 16'h7FFF);
    random_traffic(PHASE_BYTES);
    drain();

    // Low extremes; a zero weight freezes the yaw.
    program_regs(8'h00, 8'hFF, 8'h00, 16'h0000);
    random_traffic(PHASE_BYTES);
    drain();

    // High extremes, with neither side idling.
    program_regs(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
    quiet = 1'b1;
    random_traffic(PHASE_BYTES);
    drain();
    quiet = 1'b0;

    // Random settings.
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    random_traffic(PHASE_BYTES);
    drain();

    // One type code for both kinds: the angle match wins.
    program_regs(8'hAA, 8'h5A, 8'h5A, 16'h8000);
    random_traffic(PHASE_BYTES);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
